[hdl/tln_pkg.sv]
// ============================================================================
// tln_pkg: shared types and constants of the text line normalizer
// Character codes, register map, descriptor and bank release types, and the
// whitespace classifier used by the front end.
// ============================================================================
`default_nettype none

package tln_pkg;

  // Largest line buffer the design supports, and its default size.
  localparam int LINE_CAPACITY_MAX = 64;
  localparam int LINE_CAPACITY_DEF = 64;

  // Field widths fixed by the interface.
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 7;
  localparam int DESC_LEN_W = $clog2(LINE_CAPACITY_MAX);

  // Configuration port.
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;
  localparam logic REG_MAX_LINE_LEN = 1'b0;
  localparam logic [LEN_W-1:0] MAX_LINE_LEN_RST = 7'd64;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

  // One finished line handed from the front end to the back end.
  typedef struct packed {
    logic                  bank;
    logic [DESC_LEN_W-1:0] len;
    logic                  empty;
  } desc_t;

  // Back end tells the front end that a buffer bank may be reused.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

[hdl/tln_ram.sv]
// ============================================================================
// tln_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// while the read enable is low.
// ============================================================================
`default_nettype none

module tln_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tln_queue.sv]
// ============================================================================
// tln_queue: two-entry line descriptor queue
// Decouples the collecting front end from the draining back end.
// ============================================================================
`default_nettype none

module tln_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tln_pkg::desc_t push_desc,
  output logic                ready,
  input  wire logic           pop,
  output logic                head_valid,
  output tln_pkg::desc_t      head
);

  tln_pkg::desc_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  logic do_push;
  logic do_pop;

  assign ready      = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = slot[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_desc;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> ready)
    else $error("descriptor pushed into a full queue");

endmodule

`default_nettype wire

[hdl/tln_front.sv]
// ============================================================================
// tln_front: byte classifier and line collector
// Classifies each byte, collapses whitespace, writes kept characters into the
// current buffer bank and hands finished lines to the queue.
// ============================================================================
`default_nettype none

module tln_front #(
  parameter int LINE_CAPACITY = tln_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [tln_pkg::CHAR_W-1:0]           in_byte,
  input  wire logic                                 end_of_input,
  input  wire logic [tln_pkg::LEN_W-1:0]            max_line_len,
  output logic                                      we,
  output logic [$clog2(LINE_CAPACITY):0]            waddr,
  output logic [tln_pkg::CHAR_W-1:0]                wdata,
  output logic                                      push,
  output tln_pkg::desc_t                            push_desc,
  input  wire logic                                 q_ready,
  input  wire tln_pkg::bank_free_t                  bank_free
);

  localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = $clog2(LINE_CAPACITY);

  logic [CNT_W-1:0] count, count_next;
  logic             pending, pending_next;
  logic             started, started_next;
  logic             after_break, after_break_next;
  logic             last_space, last_space_next;
  logic             wbank, wbank_next;
  logic [1:0]       busy, busy_next;

  logic [CNT_W-1:0] limit;
  logic             accept;
  logic             ws;
  logic             commit_ok;
  logic [CNT_W-1:0] count_c;
  logic             last_space_c;
  logic             em_req;
  logic [CNT_W-1:0] em_n;
  logic             em_ls;
  logic [CNT_W-1:0] emit_len;

  assign limit = (max_line_len > tln_pkg::LEN_W'(LINE_CAPACITY)) ?
                 CNT_W'(LINE_CAPACITY) : CNT_W'(max_line_len);

  assign in_stall = busy[wbank] || !q_ready;
  assign accept   = in_valid && !in_stall;
  assign ws       = tln_pkg::is_ws(in_byte);

  // A pending space was already written at the fill position when its run
  // began, so committing it only advances the count.
  assign commit_ok    = pending && (count != '0) && !last_space && (count < limit);
  assign count_c      = commit_ok ? count + CNT_W'(1) : count;
  assign last_space_c = commit_ok || last_space;

  always_comb begin
    count_next       = count;
    pending_next     = pending;
    started_next     = started;
    after_break_next = after_break;
    last_space_next  = last_space;
    we               = 1'b0;
    waddr            = {wbank, ADDR_W'(count)};
    wdata            = tln_pkg::CH_SPACE;
    em_req           = 1'b0;
    em_n             = count;
    em_ls            = last_space;
    if (accept) begin
      if (end_of_input) begin
        if (started && !after_break) begin
          em_req = 1'b1;
          em_n   = count_c;
          em_ls  = last_space_c;
        end
        count_next       = '0;
        pending_next     = 1'b0;
        started_next     = 1'b0;
        last_space_next  = 1'b0;
        after_break_next = 1'b0;
      end else if (ws) begin
        if (!after_break) begin
          started_next = 1'b1;
          if (count != '0) begin
            if (in_byte == tln_pkg::CH_NEWLINE) begin
              em_req           = 1'b1;
              count_next       = '0;
              pending_next     = 1'b0;
              started_next     = 1'b0;
              last_space_next  = 1'b0;
              after_break_next = 1'b1;
            end else begin
              // The limit may still change before the run ends, so the space
              // goes in wherever the bank has room.
              pending_next = 1'b1;
              we           = (count < CNT_W'(LINE_CAPACITY));
            end
          end
        end
      end else begin
        after_break_next = 1'b0;
        started_next     = 1'b1;
        pending_next     = 1'b0;
        count_next       = count_c;
        last_space_next  = last_space_c;
        if (!in_byte[tln_pkg::CHAR_W-1] && (count_c < limit)) begin
          we              = 1'b1;
          waddr           = {wbank, ADDR_W'(count_c)};
          wdata           = in_byte;
          count_next      = count_c + CNT_W'(1);
          last_space_next = 1'b0;
        end
      end
    end
  end

  // A line is passed on only when it fit; one trailing space is trimmed.
  assign push            = em_req && (em_n < limit);
  assign emit_len        = em_ls ? em_n - CNT_W'(1) : em_n;
  assign push_desc.bank  = wbank;
  assign push_desc.len   = tln_pkg::DESC_LEN_W'(emit_len);
  assign push_desc.empty = (emit_len == '0);

  always_comb begin
    busy_next  = busy;
    wbank_next = wbank;
    if (bank_free.valid) begin
      busy_next[bank_free.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wbank] = 1'b1;
      wbank_next       = ~wbank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      pending     <= 1'b0;
      started     <= 1'b0;
      after_break <= 1'b0;
      last_space  <= 1'b0;
      wbank       <= 1'b0;
      busy        <= 2'b00;
    end else begin
      count       <= count_next;
      pending     <= pending_next;
      started     <= started_next;
      after_break <= after_break_next;
      last_space  <= last_space_next;
      wbank       <= wbank_next;
      busy        <= busy_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) we |-> !busy[wbank])
    else $error("write into a bank that is still being drained");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(LINE_CAPACITY))
    else $error("line count ran past the buffer size");

  assert property (@(posedge clk) disable iff (rst)
                   bank_free.valid |-> busy[bank_free.bank])
    else $error("release of a bank that was not handed out");

endmodule

`default_nettype wire

[hdl/tln_back.sv]
// ============================================================================
// tln_back: line drain
// Takes line descriptors from the queue, reads the line characters from the
// buffer bank and presents them one per transfer on the output channel.
// ============================================================================
`default_nettype none

module tln_back #(
  parameter int LINE_CAPACITY = tln_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            head_valid,
  input  wire tln_pkg::desc_t                  head,
  output logic                                 pop,
  output logic                                 re,
  output logic [$clog2(LINE_CAPACITY):0]       raddr,
  input  wire logic [tln_pkg::CHAR_W-1:0]      rdata,
  output tln_pkg::bank_free_t                  bank_free,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tln_pkg::CHAR_W-1:0]           out_char,
  output logic                                 line_last,
  output logic                                 line_empty
);

  localparam int ADDR_W = $clog2(LINE_CAPACITY);

  logic              active;
  logic              a_bank;
  logic [ADDR_W-1:0] a_len;
  logic              a_empty;
  logic [ADDR_W-1:0] k;
  logic              mem_v;
  logic              mem_last;
  logic              mem_empty;

  logic advance;
  logic issue;
  logic last_issue;

  // The RAM read register is the middle stage; it holds while re is low.
  assign advance    = mem_v && (!out_valid || !out_stall);
  assign issue      = active && (!mem_v || advance);
  assign last_issue = a_empty || (k == a_len - ADDR_W'(1));
  assign re         = issue && !a_empty;
  assign raddr      = {a_bank, k};
  assign pop        = !active && head_valid;

  assign bank_free.valid = issue && last_issue;
  assign bank_free.bank  = a_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      mem_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (issue && last_issue) begin
        active <= 1'b0;
      end
      if (issue) begin
        mem_v <= 1'b1;
      end else if (advance) begin
        mem_v <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_bank  <= head.bank;
      a_len   <= ADDR_W'(head.len);
      a_empty <= head.empty;
      k       <= '0;
    end else if (issue) begin
      k <= k + ADDR_W'(1);
    end
    if (issue) begin
      mem_last  <= last_issue;
      mem_empty <= a_empty;
    end
    if (advance) begin
      out_char   <= mem_empty ? tln_pkg::CH_NUL : rdata;
      line_last  <= mem_last;
      line_empty <= mem_empty;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   out_valid && line_empty |-> line_last && out_char == tln_pkg::CH_NUL)
    else $error("empty line item is malformed");

  assert property (@(posedge clk) disable iff (rst) mem_v && mem_empty |-> mem_last)
    else $error("empty line staged without end mark");

  assert property (@(posedge clk) disable iff (rst) pop |-> !mem_v || !active)
    else $error("descriptor taken while a line is still in progress");

endmodule

`default_nettype wire

[hdl/text_line_normalizer_top.sv]
// ============================================================================
// text_line_normalizer_top: whitespace-collapsing line reader
// Accepts one text byte per transfer and gives out each cleaned line as a run
// of character transfers, with a configurable line length limit.
// ============================================================================
//
//   Channel   Direction  Handshake           Payload
//   input     in         in_valid/in_stall   in_byte, end_of_input
//   output    out        out_valid/out_stall out_char, line_last, line_empty
//   config    in         APB psel/penable    max_line_len at byte address 0
//
// The front end takes one byte per cycle while its buffer bank is free.
// Lines are collected in one of two banks of LINE_CAPACITY bytes; a finished
// line is drained by the back end at one character per cycle unless the output
// stalls, while the front fills the other bank.
// The input stalls only when both banks hold lines not yet fully read out.
// Reset is synchronous; the line buffer is not cleared and needs no sweep.
// A stall on the output holds the output register and backs up into the
// bank drain; byte collection into the other bank goes on until it has finished a line.
`default_nettype none

module text_line_normalizer_top #(
  parameter int LINE_CAPACITY = tln_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tln_pkg::CHAR_W-1:0]    in_byte,
  input  wire logic                          end_of_input,
  // Output channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tln_pkg::CHAR_W-1:0]         out_char,
  output logic                               line_last,
  output logic                               line_empty,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tln_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tln_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tln_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int RAM_AW = ADDR_W + 1;

  logic [tln_pkg::LEN_W-1:0] max_line_len;
  logic                      reg_sel;

  logic                      we;
  logic [RAM_AW-1:0]         waddr;
  logic [tln_pkg::CHAR_W-1:0] wdata;
  logic                      re;
  logic [RAM_AW-1:0]         raddr;
  logic [tln_pkg::CHAR_W-1:0] rdata;

  logic                      push;
  tln_pkg::desc_t            push_desc;
  logic                      q_ready;
  logic                      pop;
  logic                      head_valid;
  tln_pkg::desc_t            head;
  tln_pkg::bank_free_t       bank_free;

  // Configuration register. Word-aligned address bit 2 selects the register;
  // writes elsewhere are ignored and read back as zero.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tln_pkg::REG_MAX_LINE_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= tln_pkg::MAX_LINE_LEN_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_line_len <= pwdata[tln_pkg::LEN_W-1:0];
    end
  end

  assign prdata = reg_sel ?
                  {{(tln_pkg::PDATA_W - tln_pkg::LEN_W){1'b0}}, max_line_len} : '0;

  tln_front #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .max_line_len (max_line_len),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .push         (push),
    .push_desc    (push_desc),
    .q_ready      (q_ready),
    .bank_free    (bank_free)
  );

  tln_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Two banks of line buffer; the bank is the top address bit.
  tln_ram #(
    .WIDTH (tln_pkg::CHAR_W),
    .DEPTH (2 ** RAM_AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  tln_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .bank_free  (bank_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .line_last  (line_last),
    .line_empty (line_empty)
  );

  // The read and write sides never touch the same bank in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
                   we && re |-> waddr[RAM_AW-1] != raddr[RAM_AW-1])
    else $error("line buffer bank read and written at once");

  assert property (@(posedge clk) disable iff (rst) push |-> !end_of_input || in_valid)
    else $error("line handed on without an input transfer");

endmodule

`default_nettype wire

[bench/text_line_normalizer_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// text_line_normalizer_top_tb: self-checking bench for the line normalizer
// Streams directed and random text through the input channel, predicts every
// cleaned line in a small scoreboard and compares each output transfer with
// it, while both channels idle at random and the length limit is varied.
// ============================================================================
`default_nettype none

module text_line_normalizer_top_tb;

  localparam int CAPACITY     = tln_pkg::LINE_CAPACITY_DEF;
  // Cycles allowed after the last expected character before the block is
  // treated as idle. A line that is dropped produces no output, so this
  // covers its pass through the pipeline.
  localparam int SETTLE_CYCLES = 30;

  // One expected output transfer.
  typedef struct {
    logic [tln_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       empty;
  } line_char_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the line being collected, turns each accepted input
  // transfer into the characters it releases, and checks output transfers
  // against them in order.
  // --------------------------------------------------------------------------
  class clean_line_model;
    logic [tln_pkg::CHAR_W-1:0] line_buf [CAPACITY];
    int unsigned       fill;
    bit                space_open;     // whitespace run without newline open
    bit                started;        // a byte of the current line was taken
    bit                in_break_run;   // whitespace run after a line end
    int unsigned       max_len;
    line_char_t        expected_chars [$];
    int                errors;
    int                bytes_taken;
    int                chars_seen;
    int                lines_out;
    int                lines_dropped;

    function new();
      restart_line();
      in_break_run  = 0;
      max_len       = int'(tln_pkg::MAX_LINE_LEN_RST);
      errors        = 0;
      bytes_taken   = 0;
      chars_seen    = 0;
      lines_out     = 0;
      lines_dropped = 0;
    endfunction

    function void set_max_len(int unsigned v);
      max_len = v & 'h7F;
    endfunction

    function bit is_white(logic [tln_pkg::CHAR_W-1:0] c);
      return (c == tln_pkg::CH_SPACE) || (c >= tln_pkg::CH_TAB && c <= tln_pkg::CH_CR);
    endfunction

    // Register values above the buffer size act as the buffer size.
    function int unsigned len_limit();
      return (max_len > CAPACITY) ? CAPACITY : max_len;
    endfunction

    function void restart_line();
      fill       = 0;
      space_open = 0;
      started    = 0;
    endfunction

    function void put_byte(logic [tln_pkg::CHAR_W-1:0] c);
      if (fill < len_limit() && fill < CAPACITY) begin
        line_buf[fill] = c;
        fill++;
      end
    endfunction

    // A closed whitespace run becomes one space unless one is already last.
    function void flush_space();
      if (space_open) begin
        space_open = 0;
        if (fill > 0 && line_buf[fill-1] != tln_pkg::CH_SPACE)
          put_byte(tln_pkg::CH_SPACE);
      end
    endfunction

    // Queues the characters of the finished line, or drops it when too long.
    function void finish_line();
      int unsigned n;
      line_char_t  r;
      n = fill;
      if (n >= len_limit()) begin
        lines_dropped++;
        return;
      end
      if (n > 0 && line_buf[n-1] == tln_pkg::CH_SPACE)
        n--;
      lines_out++;
      if (n == 0) begin
        r.ch    = tln_pkg::CH_NUL;
        r.last  = 1'b1;
        r.empty = 1'b1;
        expected_chars.push_back(r);
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        r.ch    = line_buf[k];
        r.last  = (k + 1 == n);
        r.empty = 1'b0;
        expected_chars.push_back(r);
      end
    endfunction

    function void take_input(logic [tln_pkg::CHAR_W-1:0] c, logic eoi);
      bytes_taken++;
      if (eoi) begin
        if (started && !in_break_run) begin
          flush_space();
          finish_line();
        end
        restart_line();
        in_break_run = 0;
        return;
      end
      if (is_white(c)) begin
        if (in_break_run)
          return;
        started = 1;
        if (fill == 0)
          return;
        if (c == tln_pkg::CH_NEWLINE) begin
          finish_line();
          restart_line();
          in_break_run = 1;
          return;
        end
        space_open = 1;
        return;
      end
      // Any other byte ends a whitespace run; high bytes are then dropped.
      in_break_run = 0;
      started      = 1;
      flush_space();
      if (c < 8'h80)
        put_byte(c);
    endfunction

    function void compare_char(logic [tln_pkg::CHAR_W-1:0] ch, logic last, logic empty);
      line_char_t r;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected output transfer char=%h last=%b empty=%b",
                 $time, ch, last, empty);
        errors++;
        return;
      end
      r = expected_chars.pop_front();
      // The character of an empty line carries no meaning.
      if (!r.empty && ch !== r.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, r.ch, ch);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: line_last expected %b actual %b", $time, r.last, last);
        errors++;
      end
      if (empty !== r.empty) begin
        $display("%0t: line_empty expected %b actual %b", $time, r.empty, empty);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test.
  // --------------------------------------------------------------------------
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [tln_pkg::CHAR_W-1:0]  in_byte = '0;
  logic                        end_of_input = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [tln_pkg::CHAR_W-1:0]  out_char;
  logic                        line_last;
  logic                        line_empty;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tln_pkg::PADDR_W-1:0] paddr = '0;
  logic [tln_pkg::PDATA_W-1:0] pwdata = '0;
  logic [tln_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  // Idle and stall rates in percent, changed from phase to phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  clean_line_model sb;

  // Directed opening: leading whitespace, every whitespace code, dropped high
  // bytes that close a run, NUL and DEL as ordinary characters, a flush with a
  // trailing space, end of input with nothing started, empty lines from a
  // dropped byte or whitespace alone, and the run that follows a newline.
  // Bit 8 marks an end-of-input transfer.
  logic [8:0] directed_seq [27] = '{
    9'h020, 9'h009, 9'h041, 9'h080, 9'h020, 9'h0FF, 9'h062, 9'h00D, 9'h00A,
    9'h020, 9'h00B, 9'h078, 9'h00C, 9'h000, 9'h07F, 9'h020, 9'h100, 9'h1FF,
    9'h080, 9'h155, 9'h009, 9'h100, 9'h00A, 9'h07A, 9'h00A, 9'h020, 9'h100
  };

  text_line_normalizer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .line_last    (line_last),
    .line_empty   (line_empty),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver decides at each falling edge whether to stall the next edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Every output transfer is checked at the rising edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.compare_char(out_char, line_last, line_empty);
  end

  // --------------------------------------------------------------------------
  // Driver tasks.
  // --------------------------------------------------------------------------

  // Offers one input transfer after a random gap and returns once it has been
  // accepted. While the channel idles the payload carries noise. Valid stays
  // high after acceptance so back-to-back transfers need no gap.
  task automatic send_item(input logic [tln_pkg::CHAR_W-1:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid     = 1'b0;
      in_byte      = tln_pkg::CHAR_W'($urandom);
      end_of_input = 1'($urandom_range(1));
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_byte      = b;
    end_of_input = eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_input(b, eoi);
  endtask

  // Holds the sender off until every expected character has been read out,
  // then lets the block settle so that a dropped line has also passed.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the length limit through the APB port and reads it back.
  task automatic write_max_len(input int unsigned v);
    logic [tln_pkg::PDATA_W-1:0] want;
    want = tln_pkg::PDATA_W'(v & 'h7F);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {tln_pkg::REG_MAX_LINE_LEN, 2'b00};
    pwdata  = want;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: max_line_len read expected %h actual %h", $time, want, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    sb.set_max_len(v);
  endtask

  // Random text: mostly printable words split by spaces and tabs, with
  // newlines at the given rate, and some other whitespace, high bytes,
  // control characters and end-of-input transfers mixed in.
  task automatic send_random_text(input int count, input int nl_pct);
    int          r;
    logic [7:0]  b;
    logic        eoi;
    repeat (count) begin
      r   = int'($urandom_range(99));
      eoi = 1'b0;
      if (r < nl_pct)
        b = tln_pkg::CH_NEWLINE;
      else if (r < nl_pct + 15)
        b = ($urandom_range(1) != 0) ? tln_pkg::CH_SPACE : tln_pkg::CH_TAB;
      else if (r < nl_pct + 20)
        b = 8'($urandom_range(8'h0B, 8'h0D));
      else if (r < nl_pct + 25)
        b = 8'($urandom_range(8'h80, 8'hFF));
      else if (r < nl_pct + 29) begin
        case ($urandom_range(2))
          0: b = 8'($urandom_range(8'h00, 8'h08));
          1: b = 8'($urandom_range(8'h0E, 8'h1F));
          default: b = 8'h7F;
        endcase
      end else if (r < nl_pct + 32) begin
        b   = 8'($urandom);
        eoi = 1'b1;
      end else
        b = 8'($urandom_range(8'h21, 8'h7E));
      send_item(b, eoi);
    end
  endtask

  // One unbroken word of the given length followed by a newline.
  task automatic send_long_line(input int len);
    repeat (len) send_item(tln_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E)), 1'b0);
    send_item(tln_pkg::CH_NEWLINE, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset limit, no idling on either side.
    foreach (directed_seq[i])
      send_item(directed_seq[i][7:0], directed_seq[i][8]);
    wait_drained();

    // Short limit, so that many lines exceed it.
    write_max_len(8);
    send_random_text(50, 12);
    wait_drained();

    // Register value beyond the buffer size: a 63-character line still fits,
    // a 66-character one fills the buffer and is dropped. Sender idles.
    write_max_len(127);
    send_idle_pct = 81;
    send_long_line(63);
    send_long_line(66);
    send_random_text(20, 8);
    wait_drained();

    // Limit zero drops every line; the receiver stalls most of the time.
    write_max_len(0);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    send_random_text(30, 10);
    wait_drained();

    // Limit one keeps only empty lines; light idling on both sides.
    write_max_len(1);
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    send_random_text(20, 15);
    wait_drained();

    // Limit two keeps empty lines and single characters.
    write_max_len(2);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    send_random_text(30, 15);
    wait_drained();

    // Back to the full buffer with long random lines, ending the stream.
    write_max_len(64);
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    send_random_text(60, 6);
    send_item(tln_pkg::CHAR_W'($urandom), 1'b1);
    wait_drained();

    $display("Sent %0d input transfers; %0d lines came out in %0d character transfers,",
             sb.bytes_taken, sb.lines_out, sb.chars_seen);
    $display("%0d lines were dropped over limits 0, 1, 2, 8, 64 and 127.",
             sb.lines_dropped);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
